// ===== hw/rtl/pcc_pkg.sv =====
`timescale 1ns / 1ps

package pcc_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
   localparam int COLOR_W         = 24;
   localparam int CYCLE_SLOTS     = 4;
   localparam int SLOT_W          = 2;
   localparam int RATE_W          = 16;
   localparam int TIME_W          = 32;
   localparam int RATE_DIVISOR    = 16384;
   localparam int BLEND_BITS      = 8;
   localparam int PROD_W          = RATE_W + TIME_W;
   localparam int DIV_SHIFT       = $clog2(RATE_DIVISOR) + 16;
   localparam int WHOLE_W         = PROD_W - DIV_SHIFT;
   localparam int BIT_W           = $clog2(WHOLE_W);
   localparam int SIZE_W          = IDX_W + 1;

   typedef enum logic [1:0] {
      ACT_WR_COLOR = 2'd0,
      ACT_WR_SLOT  = 2'd1,
      ACT_READ     = 2'd2,
      ACT_NONE     = 2'd3
   } pcc_action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_DIV,
      ST_APPLY,
      ST_RD_A,
      ST_RD_B,
      ST_CAP_B,
      ST_EMIT
   } pcc_state_type;

   typedef struct packed {
      logic [IDX_W-1:0]  low;
      logic [IDX_W-1:0]  high;
      logic [RATE_W-1:0] rate;
      logic              rev;
   } pcc_slot_type;

endpackage

// ===== hw/rtl/pcc_ram.sv =====
`timescale 1ns / 1ps

module pcc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/palette_color_cycler.sv =====
`timescale 1ns / 1ps

// Palette color cycler. Writes of a base color or a cycle slot are taken in the idle state,
// which they do not leave. A read walks the cycle slots from the highest down, and in blend
// mode stops at the first slot that covers the index; a covering slot forms the
// rate-times-time product, takes the bit-serial remainder of the whole steps by the range
// size and forms the rotated address. Two fetches from the base palette memory, which has a
// single read port, and the output stage follow. A finished result sits in an output
// register, and the next beat is taken while it waits to be collected.

module palette_color_cycler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic                             csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_action,
   input  logic [pcc_pkg::IDX_W-1:0]        req_index,
   input  logic [pcc_pkg::COLOR_W-1:0]      req_color,
   input  logic [pcc_pkg::SLOT_W-1:0]       req_slot,
   input  logic [pcc_pkg::IDX_W-1:0]        req_range_low,
   input  logic [pcc_pkg::IDX_W-1:0]        req_range_high,
   input  logic [pcc_pkg::RATE_W-1:0]       req_step_rate,
   input  logic                             req_reverse,
   input  logic [pcc_pkg::TIME_W-1:0]       req_time_q16,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pcc_pkg::IDX_W-1:0]        rsp_out_index,
   output logic [pcc_pkg::COLOR_W-1:0]      rsp_out_color
);

   pcc_pkg::pcc_state_type state_ff, state_in;
   pcc_pkg::pcc_slot_type  slot_ff [pcc_pkg::CYCLE_SLOTS];
   pcc_pkg::pcc_slot_type  cur;

   logic                              blend_ff;
   logic [pcc_pkg::IDX_W-1:0]         k_ff, k_in;
   logic [pcc_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [pcc_pkg::TIME_W-1:0]        t_ff, t_in;
   logic [pcc_pkg::SLOT_W-1:0]        s_ff, s_in;
   logic [pcc_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [pcc_pkg::SIZE_W-1:0]        size_ff, size_in;
   logic [pcc_pkg::IDX_W-1:0]         off_ff, off_in;
   logic [pcc_pkg::IDX_W-1:0]         low_ff, low_in;
   logic                              rev_ff, rev_in;
   logic [pcc_pkg::IDX_W-1:0]         rem_ff, rem_in;
   logic [pcc_pkg::BIT_W-1:0]         bit_ff, bit_in;
   logic [pcc_pkg::IDX_W-1:0]         addr_a_ff, addr_a_in;
   logic [pcc_pkg::IDX_W-1:0]         addr_b_ff, addr_b_in;
   logic [pcc_pkg::BLEND_BITS-1:0]    w_ff, w_in;
   logic [pcc_pkg::COLOR_W-1:0]       col_a_ff, col_a_in;
   logic [pcc_pkg::COLOR_W-1:0]       col_b_ff, col_b_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pcc_pkg::IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [pcc_pkg::COLOR_W-1:0]       rsp_color_ff, rsp_color_in;

   logic                              req_fire;
   logic                              hit;
   logic                              out_free;
   logic [pcc_pkg::WHOLE_W-1:0]       whole;
   logic [pcc_pkg::SIZE_W-1:0]        rem_shift;
   logic [pcc_pkg::SIZE_W-1:0]        sum_rev;
   logic [pcc_pkg::SIZE_W-1:0]        i1_wide;
   logic [pcc_pkg::IDX_W-1:0]         i1, i2;
   logic                              ram_we;
   logic [pcc_pkg::IDX_W-1:0]         ram_raddr;
   logic [pcc_pkg::COLOR_W-1:0]       ram_rdata;
   logic [pcc_pkg::COLOR_W-1:0]       mixed;

   pcc_ram #(
      .WIDTH(pcc_pkg::COLOR_W),
      .DEPTH(pcc_pkg::PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_index),
      .wr_data (req_color),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready     = (state_ff == pcc_pkg::ST_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign ram_we        = req_fire && (req_action == pcc_pkg::ACT_WR_COLOR);
   assign ram_raddr     = (state_ff == pcc_pkg::ST_RD_B) ? addr_b_ff : addr_a_ff;
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_color = rsp_color_ff;

   assign cur   = slot_ff[s_ff];
   assign hit   = (cur.high > cur.low) && (cur.rate != '0) && (k_ff >= cur.low)
                  && (k_ff <= cur.high);
   assign whole = prod_ff[pcc_pkg::PROD_W-1:pcc_pkg::DIV_SHIFT];

   always_comb begin
      rem_shift = {rem_ff, whole[bit_ff]};
      if (rem_shift >= size_ff) begin
         rem_shift = rem_shift - size_ff;
      end
   end

   always_comb begin
      sum_rev = {1'b0, off_ff} + {1'b0, rem_ff};
      if (rev_ff) begin
         i1_wide = (sum_rev >= size_ff) ? sum_rev - size_ff : sum_rev;
      end else if (off_ff >= rem_ff) begin
         i1_wide = {1'b0, off_ff} - {1'b0, rem_ff};
      end else begin
         i1_wide = {1'b0, off_ff} + size_ff - {1'b0, rem_ff};
      end
      i1 = i1_wide[pcc_pkg::IDX_W-1:0];
      if (rev_ff) begin
         i2 = ({1'b0, i1} + 1'b1 == size_ff) ? '0 : i1 + 1'b1;
      end else begin
         i2 = (i1 == '0) ? pcc_pkg::IDX_W'(size_ff - 1'b1) : i1 - 1'b1;
      end
   end

   always_comb begin
      logic [pcc_pkg::BLEND_BITS:0]   wa;
      logic [pcc_pkg::BLEND_BITS:0]   wb;
      logic [pcc_pkg::BLEND_BITS+9:0] acc;
      wb = {1'b0, w_ff};
      wa = (pcc_pkg::BLEND_BITS+1)'(1 << pcc_pkg::BLEND_BITS) - wb;
      mixed = '0;
      for (int c = 0; c < 3; c++) begin
         acc = (pcc_pkg::BLEND_BITS+10)'(col_a_ff[c*8 +: 8])
                  * (pcc_pkg::BLEND_BITS+10)'(wa)
             + (pcc_pkg::BLEND_BITS+10)'(col_b_ff[c*8 +: 8])
                  * (pcc_pkg::BLEND_BITS+10)'(wb)
             + (pcc_pkg::BLEND_BITS+10)'(1 << (pcc_pkg::BLEND_BITS - 1));
         mixed[c*8 +: 8] = acc[pcc_pkg::BLEND_BITS +: 8];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcc_pkg::ST_IDLE: begin
            if (req_fire && (req_action == pcc_pkg::ACT_READ)) begin
               state_in = pcc_pkg::ST_SLOT;
            end
         end
         pcc_pkg::ST_SLOT: begin
            if (hit) begin
               state_in = pcc_pkg::ST_DIV;
            end else if (s_ff == '0) begin
               state_in = pcc_pkg::ST_RD_A;
            end
         end
         pcc_pkg::ST_DIV: begin
            if (bit_ff == '0) begin
               state_in = pcc_pkg::ST_APPLY;
            end
         end
         pcc_pkg::ST_APPLY: begin
            if (blend_ff || (s_ff == '0)) begin
               state_in = pcc_pkg::ST_RD_A;
            end else begin
               state_in = pcc_pkg::ST_SLOT;
            end
         end
         pcc_pkg::ST_RD_A:  state_in = pcc_pkg::ST_RD_B;
         pcc_pkg::ST_RD_B:  state_in = pcc_pkg::ST_CAP_B;
         pcc_pkg::ST_CAP_B: state_in = pcc_pkg::ST_EMIT;
         pcc_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = pcc_pkg::ST_IDLE;
            end
         end
         default: state_in = pcc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      k_in         = k_ff;
      idx_in       = idx_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      prod_in      = prod_ff;
      size_in      = size_ff;
      off_in       = off_ff;
      low_in       = low_ff;
      rev_in       = rev_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      addr_a_in    = addr_a_ff;
      addr_b_in    = addr_b_ff;
      w_in         = w_ff;
      col_a_in     = col_a_ff;
      col_b_in     = col_b_ff;
      rsp_index_in = rsp_index_ff;
      rsp_color_in = rsp_color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         pcc_pkg::ST_IDLE: begin
            if (req_fire && (req_action == pcc_pkg::ACT_READ)) begin
               k_in   = req_index;
               idx_in = req_index;
               t_in   = req_time_q16;
               s_in   = pcc_pkg::SLOT_W'(pcc_pkg::CYCLE_SLOTS - 1);
            end
         end
         pcc_pkg::ST_SLOT: begin
            prod_in = pcc_pkg::PROD_W'(cur.rate) * pcc_pkg::PROD_W'(t_ff);
            size_in = pcc_pkg::SIZE_W'(cur.high - cur.low) + 1'b1;
            off_in  = k_ff - cur.low;
            low_in  = cur.low;
            rev_in  = cur.rev;
            rem_in  = '0;
            bit_in  = pcc_pkg::BIT_W'(pcc_pkg::WHOLE_W - 1);
            if (!hit) begin
               if (s_ff == '0) begin
                  addr_a_in = k_ff;
                  addr_b_in = k_ff;
                  w_in      = '0;
               end else begin
                  s_in = s_ff - 1'b1;
               end
            end
         end
         pcc_pkg::ST_DIV: begin
            rem_in = rem_shift[pcc_pkg::IDX_W-1:0];
            bit_in = bit_ff - 1'b1;
         end
         pcc_pkg::ST_APPLY: begin
            if (blend_ff) begin
               addr_a_in = low_ff + i1;
               addr_b_in = low_ff + i2;
               w_in      = prod_ff[pcc_pkg::DIV_SHIFT-1 -: pcc_pkg::BLEND_BITS];
            end else begin
               k_in = low_ff + i1;
               if (s_ff == '0) begin
                  addr_a_in = low_ff + i1;
                  addr_b_in = low_ff + i1;
                  w_in      = '0;
               end else begin
                  s_in = s_ff - 1'b1;
               end
            end
         end
         pcc_pkg::ST_RD_B:  col_a_in = ram_rdata;
         pcc_pkg::ST_CAP_B: col_b_in = ram_rdata;
         pcc_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_ff;
               rsp_color_in = mixed;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcc_pkg::ST_IDLE;
         blend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < pcc_pkg::CYCLE_SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            blend_ff <= csr_wr_data;
         end
         if (req_fire && (req_action == pcc_pkg::ACT_WR_SLOT)) begin
            slot_ff[req_slot] <= '{low: req_range_low, high: req_range_high,
                                   rate: req_step_rate, rev: req_reverse};
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      t_ff         <= t_in;
      s_ff         <= s_in;
      prod_ff      <= prod_in;
      size_ff      <= size_in;
      off_ff       <= off_in;
      low_ff       <= low_in;
      rev_ff       <= rev_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      addr_a_ff    <= addr_a_in;
      addr_b_ff    <= addr_b_in;
      w_ff         <= w_in;
      col_a_ff     <= col_a_in;
      col_b_ff     <= col_b_in;
      rsp_index_ff <= rsp_index_in;
      rsp_color_ff <= rsp_color_in;
   end

`ifndef ASSERT_OFF
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pcc_pkg::ST_EMIT))
      else $error("result beat raised outside the output state");

   a_rem_below_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcc_pkg::ST_DIV || state_ff == pcc_pkg::ST_APPLY)
      |-> ({1'b0, rem_ff} < size_ff))
      else $error("remainder not below range size");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_color_ff)))
      else $error("pending result beat was overwritten");
`endif

endmodule
